/* rtl/core/cmft_pkg.sv */
// Shared types and constants for the cube map face / texel address block.
// No dependencies.
package cmft_pkg;

  localparam int MAX_FACE_SIZE = 2048;
  localparam int SIZE_W        = 12;
  localparam int DIV_STEPS     = 11;   // quotient bits, q < size <= 2048
  localparam int DVD_W         = 28;   // size*(m+k)-k < 2^27
  localparam int DSR_W         = 17;   // 2k <= 65536
  localparam int MQ_DEPTH      = 4;
  localparam int OQ_DEPTH      = 16;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic [1:0] REG_FACE_SIZE = 2'd0;
  localparam logic [1:0] REG_BPP       = 2'd1;
  localparam logic [1:0] REG_FACES     = 2'd2;

  // classified lookup, front to back
  typedef struct packed {
    logic [2:0]         face;
    logic signed [16:0] mi;
    logic signed [16:0] mj;
    logic [15:0]        k;
    logic               calc;
    logic               hit;
  } item_t;

  typedef struct packed {
    logic [2:0]  face;
    logic [10:0] col;
    logic [10:0] row;
    logic [23:0] off;
    logic        hit;
  } res_t;

endpackage

/* rtl/core/cmft_front.sv */
// Front end: face selection, minor/major axis pick, and a short item queue.
// Depends on cmft_pkg.
module cmft_front import cmft_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [5:0]         faces_present,
  input  logic               size_nz,
  input  logic               deq,
  output logic               q_empty,
  output item_t              q_item
);

  logic signed [16:0] x, y, z, ax, ay, az;
  logic               z_maj, x_maj;
  item_t              cls;
  logic signed [16:0] kk;

  item_t      mem_r [MQ_DEPTH];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       wr_en;

  assign x  = 17'(dir_x);
  assign y  = 17'(dir_y);
  assign z  = 17'(dir_z);
  assign ax = x[16] ? -x : x;
  assign ay = y[16] ? -y : y;
  assign az = z[16] ? -z : z;
  assign z_maj = (az >= ay) && (az >= ax);
  assign x_maj = (ax > ay) && (ax > az);

  always_comb begin
    cls = '0;
    kk  = '0;
    if (z_maj) begin
      if (z > 0) begin
        cls.face = FACE_PZ; cls.mi = -x; cls.mj = y; kk = z;
      end else begin
        cls.face = FACE_NZ; cls.mi = x; cls.mj = y; kk = -z;
      end
    end else if (x_maj) begin
      if (x > 0) begin
        cls.face = FACE_PX; cls.mi = z; cls.mj = y; kk = x;
      end else begin
        cls.face = FACE_NX; cls.mi = -z; cls.mj = y; kk = -x;
      end
    end else begin
      if (y > 0) begin
        cls.face = FACE_PY; cls.mi = x; cls.mj = z; kk = y;
      end else begin
        cls.face = FACE_NY; cls.mi = x; cls.mj = -z; kk = -y;
      end
    end
    cls.k    = kk[15:0];
    cls.hit  = (kk != '0) && faces_present[cls.face];
    cls.calc = cls.hit && size_nz;
  end

  assign full    = (cnt_r == 3'(MQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_item  = mem_r[rd_r];
  assign wr_en   = push && !full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !deq) cnt_nxt = cnt_r + 3'd1;
    else if (!wr_en && deq) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) wr_r <= wr_r + 2'd1;
      if (deq)   rd_r <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_r] <= cls;
  end

endmodule

/* rtl/core/cmft_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cmft_pkg.
module cmft_div import cmft_pkg::*; (
  input  logic                 clk,
  input  logic [DVD_W-1:0]     in_dvd,
  input  logic [DSR_W-1:0]     in_dsr,
  output logic [DIV_STEPS-1:0] out_quo
);

  logic [DVD_W-1:0]     rem_r [DIV_STEPS];
  logic [DSR_W-1:0]     dsr_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    logic [DVD_W-1:0]     rem_i, dsh;
    logic [DSR_W-1:0]     dsr_i;
    logic [DIV_STEPS-1:0] quo_i;
    logic                 ge;
    if (s == 0) begin : g_first
      assign rem_i = in_dvd;
      assign dsr_i = in_dsr;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign dsr_i = dsr_r[s-1];
      assign quo_i = quo_r[s-1];
    end
    assign dsh = DVD_W'(dsr_i) << (DIV_STEPS - 1 - s);
    assign ge  = rem_i >= dsh;
    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? rem_i - dsh : rem_i;
      dsr_r[s] <= dsr_i;
      quo_r[s] <= quo_i | (DIV_STEPS'(ge) << (DIV_STEPS - 1 - s));
    end
  end

  assign out_quo = quo_r[DIV_STEPS-1];

endmodule

/* rtl/core/cmft_back.sv */
// Back end: numerators, two pipelined dividers for col/row, byte offset.
// Depends on cmft_pkg and cmft_div.
module cmft_back import cmft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              issue,
  input  item_t             item,
  input  logic [SIZE_W-1:0] size,
  input  logic [2:0]        bpp,
  output logic              res_vld,
  output res_t              res
);

  typedef struct packed {
    logic [2:0] face;
    logic       hit;
  } side_t;

  logic signed [17:0] sj, si;
  logic [28:0]        pj, pi;
  logic signed [29:0] nj, ni;
  logic [DVD_W-1:0]   dvd_u_nxt, dvd_v_nxt;

  logic                 a_vld_r;
  side_t                a_sd_r;
  logic [DVD_W-1:0]     dvd_u_r, dvd_v_r;
  logic [DSR_W-1:0]     dsr_r;
  logic [DIV_STEPS-1:0] sv_r;
  side_t                sd_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_u, quo_v;

  logic        b_vld_r;
  side_t       b_sd_r;
  logic [10:0] b_u_r, b_v_r;
  logic [22:0] b_rm_r;
  logic [23:0] base;

  // numerator size*(m+k)-k, clamped at zero
  assign sj = 18'(item.mj) + $signed({2'b0, item.k});
  assign si = 18'(item.mi) + $signed({2'b0, item.k});
  assign pj = 29'(size) * 29'(sj[16:0]);
  assign pi = 29'(size) * 29'(si[16:0]);
  assign nj = $signed({1'b0, pj}) - $signed({14'b0, item.k});
  assign ni = $signed({1'b0, pi}) - $signed({14'b0, item.k});
  assign dvd_u_nxt = (!item.calc || nj[29]) ? '0 : nj[DVD_W-1:0];
  assign dvd_v_nxt = (!item.calc || ni[29]) ? '0 : ni[DVD_W-1:0];

  always_ff @(posedge clk) begin
    a_sd_r  <= '{face: item.face, hit: item.hit};
    dvd_u_r <= dvd_u_nxt;
    dvd_v_r <= dvd_v_nxt;
    dsr_r   <= item.calc ? {item.k, 1'b0} : DSR_W'(1);
  end

  cmft_div u_div_col (.clk(clk), .in_dvd(dvd_u_r), .in_dsr(dsr_r), .out_quo(quo_u));
  cmft_div u_div_row (.clk(clk), .in_dvd(dvd_v_r), .in_dsr(dsr_r), .out_quo(quo_v));

  always_ff @(posedge clk) begin
    sd_r[0] <= a_sd_r;
    for (int s = 1; s < DIV_STEPS; s++) sd_r[s] <= sd_r[s-1];
  end

  always_ff @(posedge clk) begin
    b_sd_r <= sd_r[DIV_STEPS-1];
    b_u_r  <= quo_u;
    b_v_r  <= quo_v;
    b_rm_r <= 23'(quo_v) * 23'(size);
  end

  assign base = 24'(b_rm_r) + 24'(b_u_r);

  always_ff @(posedge clk) begin
    res.face <= b_sd_r.face;
    res.hit  <= b_sd_r.hit;
    res.col  <= b_u_r;
    res.row  <= b_v_r;
    res.off  <= 24'(base * 24'(bpp));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      sv_r    <= '0;
      b_vld_r <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      a_vld_r <= issue;
      sv_r    <= {sv_r[DIV_STEPS-2:0], a_vld_r};
      b_vld_r <= sv_r[DIV_STEPS-1];
      res_vld <= b_vld_r;
    end
  end

endmodule

/* rtl/core/cube_map_face_texel_address.sv */
// Cube map face select and texel address, top level: config regs, credit, result queue.
// Throughput: one beat per cycle while a result queue credit is free, set by the
// fully pipelined back end (one quotient bit per divider stage); the credit loop
// covers the 14-deep back end pipeline.
// Reset (rst_n low, synchronous): queues empty, face_size 256, bytes_per_texel 3,
// faces_present 0.
module cube_map_face_texel_address import cmft_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_face_index,
  output logic [10:0]        out_texel_col,
  output logic [10:0]        out_texel_row,
  output logic [23:0]        out_byte_offset,
  output logic               out_hit,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [11:0]        cfg_data
);

  // configuration
  logic [SIZE_W-1:0] face_size_r;
  logic [2:0]        bpp_r;
  logic [5:0]        faces_r;
  logic [SIZE_W-1:0] size_eff;

  // front/back handoff
  logic  q_empty, issue;
  item_t q_item;
  logic  bk_vld;
  res_t  bk_res;

  // result queue and credit: credits = free queue slots not claimed by beats in flight
  res_t       oq_r [OQ_DEPTH];
  logic [3:0] oq_wr_r, oq_rd_r;
  logic [4:0] oq_cnt_r, oq_cnt_nxt;
  logic [4:0] credit_r, credit_nxt;
  logic       oq_pop;
  res_t       oq_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r <= 12'd256;
      bpp_r       <= 3'd3;
      faces_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FACE_SIZE: face_size_r <= cfg_data;
        REG_BPP:       bpp_r       <= cfg_data[2:0];
        REG_FACES:     faces_r     <= cfg_data[5:0];
        default:       ;
      endcase
    end
  end

  assign size_eff = (face_size_r > SIZE_W'(MAX_FACE_SIZE)) ? SIZE_W'(MAX_FACE_SIZE)
                                                           : face_size_r;

  cmft_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .dir_x(in_dir_x), .dir_y(in_dir_y), .dir_z(in_dir_z),
    .faces_present(faces_r), .size_nz(size_eff != '0),
    .deq(issue), .q_empty(q_empty), .q_item(q_item)
  );

  // issue only with a reserved slot in the result queue
  assign issue = !q_empty && (credit_r != '0);

  cmft_back u_back (
    .clk(clk), .rst_n(rst_n), .issue(issue), .item(q_item),
    .size(size_eff), .bpp(bpp_r), .res_vld(bk_vld), .res(bk_res)
  );

  assign empty  = (oq_cnt_r == '0);
  assign oq_pop = pop && !empty;
  assign oq_head = oq_r[oq_rd_r];

  assign out_face_index  = oq_head.face;
  assign out_texel_col   = oq_head.col;
  assign out_texel_row   = oq_head.row;
  assign out_byte_offset = oq_head.off;
  assign out_hit         = oq_head.hit;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (bk_vld && !oq_pop) oq_cnt_nxt = oq_cnt_r + 5'd1;
    else if (!bk_vld && oq_pop) oq_cnt_nxt = oq_cnt_r - 5'd1;
    credit_nxt = credit_r;
    if (issue && !oq_pop) credit_nxt = credit_r - 5'd1;
    else if (!issue && oq_pop) credit_nxt = credit_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
      credit_r <= 5'(OQ_DEPTH);
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      credit_r <= credit_nxt;
      if (bk_vld) oq_wr_r <= oq_wr_r + 4'd1;
      if (oq_pop) oq_rd_r <= oq_rd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_vld) oq_r[oq_wr_r] <= bk_res;
  end

  // result queue never overflows: back end beats are always covered by a credit
  a_oq_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(bk_vld && !oq_pop && oq_cnt_r == 5'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    6'(credit_r) + 6'(oq_cnt_r) <= 6'(OQ_DEPTH))
    else $error("credit plus queued beats exceed queue depth");

  a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> credit_r != '0)
    else $error("issue without credit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_hit) |-> (out_byte_offset == '0 && out_texel_col == '0))
    else $error("miss beat carries nonzero address");

endmodule

/* tb/cmft_scoreboard.sv */
// Lookup-result scoreboard for the cube map face / texel address testbench.
// Depends on cmft_pkg (res_t, face codes, MAX_FACE_SIZE).
`timescale 1ns / 1ps

class cmft_scoreboard;
  cmft_pkg::res_t lookups_due[$];
  logic [11:0]    face_size;
  logic [2:0]     bytes_per_texel;
  logic [5:0]     faces_present;
  int             errors;

  function new();
    face_size       = 12'd256;
    bytes_per_texel = 3'd3;
    faces_present   = 6'd0;
    errors          = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [11:0] data);
    if (idx == cmft_pkg::REG_FACE_SIZE) face_size = data;
    else if (idx == cmft_pkg::REG_BPP) bytes_per_texel = data[2:0];
    else if (idx == cmft_pkg::REG_FACES) faces_present = data[5:0];
  endfunction

  // floor((size*(m+k)-k)/(2k)), clamped to [0, size-1]
  function longint texel_coord(longint m, longint k, longint size);
    longint num;
    longint q;
    num = size * (m + k) - k;
    if (num < 0) return 0;
    q = num / (2 * k);
    if (q > size - 1) q = size - 1;
    return q;
  endfunction

  function void note_lookup(logic signed [15:0] dx, logic signed [15:0] dy,
                            logic signed [15:0] dz);
    cmft_pkg::res_t r;
    longint x, y, z, ax, ay, az, i, j, k, size;
    x = dx; y = dy; z = dz;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    r = '0;
    if (az >= ay && az >= ax) begin
      if (z > 0) begin r.face = cmft_pkg::FACE_PZ; i = -x; j = y; k = z; end
      else begin r.face = cmft_pkg::FACE_NZ; i = x; j = y; k = -z; end
    end else if (ax > ay && ax > az) begin
      if (x > 0) begin r.face = cmft_pkg::FACE_PX; i = z; j = y; k = x; end
      else begin r.face = cmft_pkg::FACE_NX; i = -z; j = y; k = -x; end
    end else begin
      if (y > 0) begin r.face = cmft_pkg::FACE_PY; i = x; j = z; k = y; end
      else begin r.face = cmft_pkg::FACE_NY; i = x; j = -z; k = -y; end
    end
    size = face_size;
    if (size > cmft_pkg::MAX_FACE_SIZE) size = cmft_pkg::MAX_FACE_SIZE;
    if (k > 0 && faces_present[r.face]) begin
      r.hit = 1'b1;
      if (size > 0) begin
        longint u, v;
        u = texel_coord(j, k, size);
        v = texel_coord(i, k, size);
        r.col = u[10:0];
        r.row = v[10:0];
        r.off = 24'((v * size + u) * bytes_per_texel);
      end
    end
    lookups_due.push_back(r);
  endfunction

  function void check_result(cmft_pkg::res_t got);
    cmft_pkg::res_t want;
    if (lookups_due.size() == 0) begin
      $display("%0t: unexpected result face=%0d col=%0d row=%0d off=%0d hit=%0d",
               $time, got.face, got.col, got.row, got.off, got.hit);
      errors++;
      return;
    end
    want = lookups_due.pop_front();
    if (got.face != want.face) begin
      $display("%0t: face exp %0d got %0d", $time, want.face, got.face); errors++;
    end
    if (got.col != want.col) begin
      $display("%0t: col exp %0d got %0d", $time, want.col, got.col); errors++;
    end
    if (got.row != want.row) begin
      $display("%0t: row exp %0d got %0d", $time, want.row, got.row); errors++;
    end
    if (got.off != want.off) begin
      $display("%0t: off exp %0d got %0d", $time, want.off, got.off); errors++;
    end
    if (got.hit != want.hit) begin
      $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit); errors++;
    end
  endfunction
endclass

/* tb/testbench.sv */
// Top-level testbench for cube_map_face_texel_address: drives lookups and
// register writes, checks every result beat. Depends on cmft_pkg, cmft_scoreboard.
`timescale 1ns / 1ps

module testbench;
  import cmft_pkg::*;

  localparam int LATENCY   = 16;
  localparam int CYCLE_CAP = 400000;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic               empty;
  logic               pop;
  logic [2:0]         out_face_index;
  logic [10:0]        out_texel_col, out_texel_row;
  logic [23:0]        out_byte_offset;
  logic               out_hit;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [11:0]        cfg_data;

  cmft_scoreboard lookups = new();
  int  cycles;
  bit  hold_off_req;   // sender asks the receiver for a long stall
  bit  holding;        // receiver is in the long stall
  bit  stall_free;     // receiver pops every cycle during a stretch

  cube_map_face_texel_address dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .empty(empty), .pop(pop),
    .out_face_index(out_face_index), .out_texel_col(out_texel_col),
    .out_texel_row(out_texel_row), .out_byte_offset(out_byte_offset),
    .out_hit(out_hit),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: sample at rising edge, pop pattern changes at falling edge
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      lookups.check_result('{face: out_face_index, col: out_texel_col,
                             row: out_texel_row, off: out_byte_offset, hit: out_hit});
  end

  initial begin
    int pat;
    int n;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        // long stall so the queue fills and full pushes back
        @(negedge clk) pop <= 1'b0;
        holding = 1;
        repeat (200) @(negedge clk);
        holding = 0;
        hold_off_req = 0;
      end
      pat = $urandom_range(0, 3);
      n = $urandom_range(1, 40);
      repeat (n) begin
        @(negedge clk);
        if (stall_free) pop <= 1'b1;
        else begin
          case (pat)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ~pop;
          endcase
        end
      end
    end
  end

  // one lookup beat; call right after a falling edge, leaves push high
  task automatic send_lookup(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    push <= 1'b1;
    in_dir_x <= x; in_dir_y <= y; in_dir_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    lookups.note_lookup(x, y, z);
    @(negedge clk);
  endtask

  task automatic idle_push();
    push <= 1'b0;
  endtask

  // drain all expected results, then let the pipe settle
  task automatic drain();
    idle_push();
    while (lookups.lookups_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    lookups.write_reg(idx, data);
  endtask

  function automatic logic signed [15:0] rnd_comp(int span);
    int v;
    v = $urandom_range(0, span);
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 63) == 0) v = -32768;
    return 16'(v);
  endfunction

  // burst of random lookups with random gaps between bursts
  task automatic random_lookups(int count);
    int sent;
    int burst;
    int span;
    logic signed [15:0] x, y, z;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        case ($urandom_range(0, 5))
          0: span = 32767;
          1: span = 255;
          2: span = 7;
          default: span = 32767;
        endcase
        x = rnd_comp(span); y = rnd_comp(span); z = rnd_comp(span);
        case ($urandom_range(0, 9))
          0: y = x;                // ties between axes
          1: z = (($urandom_range(0, 1)) ? x : -x);
          2: x = '0;
          3: begin
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
          end
          default: ;
        endcase
        send_lookup(x, y, z);
        sent++; burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_push();
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    idle_push();
  endtask

  initial begin
    int phase;
    logic [11:0] sizes [7];
    logic [11:0] bpps  [5];
    rst_n = 1'b0; push = 1'b0; cfg_we = 1'b0; cfg_idx = REG_FACE_SIZE; cfg_data = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0;
    cycles = 0; hold_off_req = 0; holding = 0; stall_free = 0;
    sizes = '{12'd1, 12'd2048, 12'd4095, 12'd0, 12'd3, 12'd256, 12'd1000};
    bpps  = '{12'd1, 12'd4, 12'd7, 12'd0, 12'd3};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: no faces present, every lookup misses
    send_lookup(16'sd100, 16'sd2, 16'sd3);
    send_lookup(16'sd0, 16'sd0, 16'sd0);
    drain();

    write_reg(REG_FACES, 12'h03F);
    write_reg(REG_FACE_SIZE, 12'd2048);
    write_reg(REG_BPP, 12'd4);
    write_reg(2'd3, 12'hFFF);   // unmapped index, ignored
    // directed: each face, ties, zero vector, extremes, corners
    send_lookup(16'sd1000, 16'sd0, 16'sd0);
    send_lookup(-16'sd1000, 16'sd5, -16'sd7);
    send_lookup(16'sd1, 16'sd1000, -16'sd3);
    send_lookup(16'sd0, -16'sd1000, 16'sd999);
    send_lookup(16'sd0, 16'sd0, 16'sd1);
    send_lookup(16'sd4, -16'sd9, -16'sd500);
    send_lookup(16'sd0, 16'sd0, 16'sd0);
    send_lookup(16'sd77, 16'sd77, 16'sd77);
    send_lookup(16'sd77, 16'sd77, 16'sd5);
    send_lookup(-16'sd77, 16'sd77, 16'sd5);
    send_lookup(-16'sh8000, -16'sh8000, -16'sh8000);
    send_lookup(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_lookup(16'sh7FFF, -16'sh8000, 16'sh7FFF);
    send_lookup(16'sh7FFF, 16'sh7FFF, -16'sh8000);
    send_lookup(16'sh7FFF, -16'sh7FFF, 16'sh7FFF);
    send_lookup(16'sd10, 16'sd10, -16'sd10);
    send_lookup(16'sd5, -16'sd5, 16'sd2);
    drain();

    // faces +X, +Y and +Z absent (mask 0x2A), face size above the max
    write_reg(REG_FACES, 12'h02A);
    write_reg(REG_FACE_SIZE, 12'd4095);   // clamped to the max face size
    random_lookups(60);
    drain();

    for (phase = 0; phase < 14; phase++) begin
      write_reg(REG_FACE_SIZE, sizes[phase % 7]);
      write_reg(REG_BPP, bpps[phase % 5]);
      write_reg(REG_FACES, (phase % 4 == 0) ? 12'h03F : 12'($urandom_range(0, 63)));
      if (phase == 3) begin
        // fill the block while the receiver holds off
        hold_off_req = 1;
        wait (holding);
        random_lookups(60);
      end else if (phase == 6) begin
        stall_free = 1;
        random_lookups(100);
        stall_free = 0;
      end else
        random_lookups(110);
      drain();   // sender pauses until everything is back
    end

    write_reg(REG_FACES, 12'h000);
    random_lookups(40);
    drain();

    if (lookups.errors == 0 && lookups.lookups_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
